### rtl/core/lpc_pkg.sv
package lpc_pkg;

    localparam int ANGLE_W     = 16;
    localparam int DIST_W      = 18;
    localparam int COORD_W     = 19;
    localparam int TDATA_IN_W  = 40;
    localparam int TDATA_OUT_W = 40;

    // CORDIC datapath: 12 guard bits on top of the Q2 distance
    localparam int GUARD_BITS  = 12;
    localparam int STEPS       = 30;
    localparam int CW          = 33;
    localparam int ZW          = 33;

    // 1 / CORDIC gain in Q32
    localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74_EDA8;
    localparam int          COORD_LIMIT  = 262143;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN32 [STEPS] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
        32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [1:0]           quad;
    } t_cordic;

endpackage

### rtl/core/lpc_gain.sv
module lpc_gain
    import lpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ANGLE_W-1:0]  i_angle,
    input  logic [DIST_W-1:0]   i_dist,
    output logic                o_valid,
    input  logic                i_ready,
    output t_cordic             o_data
);

    logic               r_in_valid;
    logic [ANGLE_W-1:0] r_angle;
    logic [DIST_W-1:0]  r_dist;
    logic               r_valid;
    t_cordic            r_data;

    logic               mul_ready;
    logic [29:0]        dist_sh;
    logic [61:0]        prod;
    logic [62:0]        rsum;
    t_cordic            n_data;

    assign mul_ready = !r_valid || i_ready;
    assign o_ready   = !r_in_valid || mul_ready;

    // scale by the inverse gain, round half up
    always_comb begin
        dist_sh     = {r_dist, {GUARD_BITS{1'b0}}};
        prod        = 62'(dist_sh) * 62'(INV_GAIN_Q32);
        rsum        = {1'b0, prod} + 63'h0_8000_0000;
        n_data.x    = $signed({2'b00, rsum[62:32]});
        n_data.y    = '0;
        n_data.z    = $signed({3'b000, r_angle[13:0], 16'h0000});
        n_data.quad = r_angle[15:14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (mul_ready) r_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_angle <= i_angle;
            r_dist  <= i_dist;
        end
        if (r_in_valid && mul_ready) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/lpc_cordic_stage.sv
module lpc_cordic_stage
    import lpc_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_cordic i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_cordic o_data
);

    logic                 r_valid;
    t_cordic              r_data;
    t_cordic              n_data;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;

    assign o_ready = !r_valid || i_ready;

    // one micro-rotation; arithmetic shifts floor toward minus infinity
    always_comb begin
        dx          = i_data.y >>> STAGE;
        dy          = i_data.x >>> STAGE;
        at          = $signed({1'b0, ATAN_TURN32[STAGE]});
        n_data.quad = i_data.quad;
        if (!i_data.z[ZW-1]) begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - at;
        end else begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/lpc_output.sv
module lpc_output
    import lpc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 2
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_cordic                   i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COORD_W-1:0] o_x,
    output logic signed [COORD_W-1:0] o_y
);

    localparam int SH = GUARD_BITS + 2 - COORD_FRAC_BITS;
    localparam logic [CW:0] HALF = {{CW{1'b0}}, 1'b1} << (SH - 1);
    localparam logic signed [CW:0] LIM = (CW + 1)'(COORD_LIMIT);

    logic                      r_valid;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [CW-1:0]      ox;
    logic signed [CW-1:0]      oy;

    // round half up to the output scale, then saturate
    function automatic logic signed [COORD_W-1:0] to_field(input logic signed [CW-1:0] v);
        logic signed [CW:0] sum;
        logic signed [CW:0] sv;
        logic signed [CW:0] cl;
        sum = $signed({v[CW-1], v}) + $signed(HALF);
        sv  = sum >>> SH;
        if (sv > LIM) cl = LIM;
        else if (sv < -LIM) cl = -LIM;
        else cl = sv;
        return cl[COORD_W-1:0];
    endfunction

    // rotate the first-quadrant result back into its quadrant
    always_comb begin
        unique case (i_data.quad)
            QUAD_0: begin ox = i_data.x;  oy = i_data.y;  end
            QUAD_1: begin ox = -i_data.y; oy = i_data.x;  end
            QUAD_2: begin ox = -i_data.x; oy = -i_data.y; end
            QUAD_3: begin ox = i_data.y;  oy = -i_data.x; end
            default: begin ox = i_data.x; oy = i_data.y;  end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x <= to_field(ox);
            r_y <= to_field(oy);
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

### rtl/core/lidar_polar_to_cartesian_core.sv
// Lidar polar-to-Cartesian converter.
//
// Slave stream (s): one item per measurement. tdata carries the angle
// (16-bit binary angle, full circle = 2^16) and the distance (mm, Q2).
// Master stream (m): one item per accepted input, x = d*cos, y = d*sin,
// signed, mm with COORD_FRAC_BITS fractional bits, saturated to +-262143.
//
// Throughput: one item per cycle while the master side accepts. The accepting
// edge loads the input register; the item then passes the gain multiply
// register, 30 CORDIC micro-rotation stages and the round/clamp output
// register before it reaches the master side.
// The rate is set by the pipelined CORDIC: every stage holds one item.
//
// Each stage has its own valid bit and a ready that looks one stage ahead,
// so a stall on the master side fills the bubbles first; the slave side
// keeps accepting until every stage holds an item. Stalled results hold.
//
// Reset (synchronous, active low) clears all valid bits; items in flight
// are dropped. No configuration, no state between items.
module lidar_polar_to_cartesian_core
    import lpc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 2
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,   // [15:0] angle_q14, [33:16] dist_q2, pad 0
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [TDATA_OUT_W-1:0] o_m_tdata    // [18:0] x_mm_q2, [37:19] y_mm_q2, pad 0
);

    t_cordic                   st_data  [STEPS+1];
    logic                      st_valid [STEPS+1];
    logic                      st_ready [STEPS+1];
    logic signed [COORD_W-1:0] x_mm_q2;
    logic signed [COORD_W-1:0] y_mm_q2;

    // input register and gain correction
    lpc_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_angle (i_s_tdata[ANGLE_W-1:0]),
        .i_dist  (i_s_tdata[ANGLE_W+DIST_W-1:ANGLE_W]),
        .o_valid (st_valid[0]),
        .i_ready (st_ready[0]),
        .o_data  (st_data[0])
    );

    // one micro-rotation per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        lpc_cordic_stage #(
            .STAGE (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[k]),
            .o_ready (st_ready[k]),
            .i_data  (st_data[k]),
            .o_valid (st_valid[k+1]),
            .i_ready (st_ready[k+1]),
            .o_data  (st_data[k+1])
        );
    end

    // quadrant fold back, rounding, saturation, result register
    lpc_output #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_output (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[STEPS]),
        .o_ready (st_ready[STEPS]),
        .i_data  (st_data[STEPS]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_x     (x_mm_q2),
        .o_y     (y_mm_q2)
    );

    assign o_m_tdata = {{(TDATA_OUT_W - 2*COORD_W){1'b0}}, y_mm_q2, x_mm_q2};

endmodule

### rtl/core/lpc_checker.sv
module lpc_checker
    import lpc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   o_s_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,
    input  logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [TDATA_OUT_W-1:0] o_m_tdata
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // an empty output register means the whole pipe can take an item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // saturation never yields the most negative code
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[18:0] != 19'h40000) && (o_m_tdata[37:19] != 19'h40000)
                       && (o_m_tdata[39:38] == 2'b00))
        else $error("result field out of range");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

endmodule

bind lidar_polar_to_cartesian_core lpc_checker u_lpc_checker (.*);

### dv/lidar_polar_to_cartesian_core_checker.sv
`timescale 1ns / 1ps

module lidar_polar_to_cartesian_core_checker
    import lpc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 2
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,   // [15:0] angle_q14, [33:16] dist_q2, pad 0
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [TDATA_OUT_W-1:0] i_m_tdata,   // [18:0] x_mm_q2, [37:19] y_mm_q2, pad 0
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_xy;

    t_xy xy_expected_q[$];

    // Round the CORDIC value (guard + 2 fraction bits) to the output scale, then clamp.
    function automatic logic signed [COORD_W-1:0] round_to_coord(input longint v);
        int     sh;
        longint r;
        sh = GUARD_BITS + 2 - COORD_FRAC_BITS;
        r  = (v + (longint'(1) << (sh - 1))) >>> sh;
        if (r > COORD_LIMIT)
            r = COORD_LIMIT;
        if (r < -COORD_LIMIT)
            r = -COORD_LIMIT;
        return r[COORD_W-1:0];
    endfunction

    function automatic t_xy polar_to_xy(input logic [ANGLE_W-1:0] angle,
                                        input logic [DIST_W-1:0]  distance);
        logic [63:0] prod;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        longint      ox;
        longint      oy;
        logic [1:0]  quad;
        t_xy         res;
        quad = angle[15:14];
        z    = longint'(angle[13:0]) << 16;
        // pre-scale by the inverse CORDIC gain, round half up
        prod = {34'b0, distance, 12'b0} * {32'b0, INV_GAIN_Q32};
        prod = prod + 64'h8000_0000;
        x    = longint'({32'b0, prod[63:32]});
        y    = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'({32'b0, ATAN_TURN32[i]});
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'({32'b0, ATAN_TURN32[i]});
            end
        end
        case (quad)
            QUAD_0: begin
                ox = x;  oy = y;
            end
            QUAD_1: begin
                ox = -y; oy = x;
            end
            QUAD_2: begin
                ox = -x; oy = -y;
            end
            default: begin
                ox = y;  oy = -x;
            end
        endcase
        res.x = round_to_coord(ox);
        res.y = round_to_coord(oy);
        return res;
    endfunction

    int fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_xy                       want;
        logic signed [COORD_W-1:0] got_x;
        logic signed [COORD_W-1:0] got_y;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                xy_expected_q.push_back(polar_to_xy(i_s_tdata[15:0], i_s_tdata[33:16]));
            if (i_m_tvalid && i_m_tready) begin
                got_x = i_m_tdata[18:0];
                got_y = i_m_tdata[37:19];
                if (xy_expected_q.size() == 0) begin
                    $display("%0t: unexpected item, got x %0d y %0d", $time, got_x, got_y);
                    fail_count++;
                end else begin
                    want = xy_expected_q.pop_front();
                    if (got_x !== want.x) begin
                        $display("%0t: x_mm_q2 mismatch, expected %0d, got %0d",
                                 $time, want.x, got_x);
                        fail_count++;
                    end
                    if (got_y !== want.y) begin
                        $display("%0t: y_mm_q2 mismatch, expected %0d, got %0d",
                                 $time, want.y, got_y);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= xy_expected_q.size();
    end

endmodule

### dv/lidar_polar_to_cartesian_core_tb.sv
`timescale 1ns / 1ps

module lidar_polar_to_cartesian_core_tb;
    import lpc_pkg::*;

    localparam int COORD_FRAC_BITS = 2;
    localparam int RANDOM_ITEMS    = 777;
    // Pressure phase: the receiver holds off well past the pipeline depth
    localparam int HOLD_AT         = 300;
    localparam int HOLD_ITEMS      = 150;
    localparam int HOLD_CYCLES     = 200;
    // Drain time at the end, somewhat longer than the pipeline depth
    localparam int DRAIN_CYCLES    = 60;
    localparam int CYCLE_LIMIT     = 400000;

    logic                   i_clk;
    logic                   i_rst_n   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;   // [15:0] angle_q14, [33:16] dist_q2, pad 0
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;          // [18:0] x_mm_q2, [37:19] y_mm_q2, pad 0

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Sender burst state; steady suppresses gaps during the pressure phase
    int burst_left  = 0;
    bit steady      = 1'b0;
    // Raised by the sender to ask the receiver for its long hold-off
    bit hold_go     = 1'b0;

    lidar_polar_to_cartesian_core #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    lidar_polar_to_cartesian_core_checker #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: anything still running here is hung
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: segments of always-ready, coin-flip, mostly-stalled and mostly-ready,
    // plus one long hold-off on request so the pipeline fills and backs up.
    initial begin
        int seg_mode;
        int seg_left;
        int hold_left;
        bit hold_done;
        seg_mode  = 0;
        seg_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_go && !hold_done) begin
                m_tready  <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(1, 60);
                end
                seg_left--;
                case (seg_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offer one item and hold it until accepted; then either go on or drop
    // valid for a random gap, with junk on tdata while idle.
    task automatic send_item(input logic [ANGLE_W-1:0] angle,
                             input logic [DIST_W-1:0]  dist_q2);
        int gap;
        s_tdata  <= {6'b0, dist_q2, angle};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        if (!steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                s_tdata  <= TDATA_IN_W'({$urandom, $urandom});
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(0, 30);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_random_item();
        logic [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]  dist_q2;
        // mostly any angle; sometimes hug a quadrant boundary
        if ($urandom_range(0, 4) == 0)
            angle = ANGLE_W'(($urandom_range(0, 3) << 14) + $urandom_range(0, 4) - 2);
        else
            angle = ANGLE_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
            0:       dist_q2 = '0;
            1:       dist_q2 = DIST_W'($urandom_range(0, 64));
            2:       dist_q2 = DIST_W'(32'h3FFFF - $urandom_range(0, 255));
            default: dist_q2 = DIST_W'($urandom_range(0, 262143));
        endcase
        send_item(angle, dist_q2);
    endtask

    initial begin
        burst_left = $urandom_range(0, 30);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: quadrant corners at full range, zero distance, tiny distances,
        // the extreme angle codes and the diagonals.
        send_item(16'h0000, 18'h3FFFF);
        send_item(16'h4000, 18'h3FFFF);
        send_item(16'h8000, 18'h3FFFF);
        send_item(16'hC000, 18'h3FFFF);
        send_item(16'hFFFF, 18'h3FFFF);
        send_item(16'h0001, 18'h3FFFF);
        send_item(16'h3FFF, 18'h3FFFF);
        send_item(16'h2000, 18'h3FFFF);
        send_item(16'h6000, 18'h3FFFF);
        send_item(16'hA000, 18'h3FFFF);
        send_item(16'hE000, 18'h3FFFF);
        send_item(16'h0000, 18'h00000);
        send_item(16'hFFFF, 18'h00000);
        send_item(16'h5A5A, 18'h00000);
        send_item(16'h0000, 18'h00001);
        send_item(16'h4000, 18'h00001);
        send_item(16'h8000, 18'h00002);
        send_item(16'hC000, 18'h00003);
        send_item(16'h1234, 18'h00004);
        send_item(16'hAAAA, 18'h15555);
        send_item(16'h5555, 18'h2AAAA);
        send_item(16'h7FFF, 18'h20000);
        send_item(16'h8001, 18'h1FFFF);

        // Random, with one back-to-back stretch against a long receiver hold-off
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT) begin
                steady  = 1'b1;
                hold_go = 1'b1;
                for (int k = 0; k < HOLD_ITEMS; k++)
                    send_random_item();
                steady = 1'b0;
            end
            send_random_item();
        end
        s_tvalid <= 1'b0;

        // Drain: let the last acceptance reach the count, wait for every
        // expected item, then a little longer for strays
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
